@@ design/mts_pkg.sv @@
// Shared types and codes for the min-tracking stack.
// Holds the request, response and stored-entry structs and the operation codes.
// Depends on nothing; every design file imports it.
package mts_pkg;

   // Operation codes carried in the mode field. The unused code acts as a peek.
   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_PEEK = 2'd2;

   // Value shown for top and minimum while the stack is empty.
   localparam logic signed [31:0] EMPTY_READ = -32'sd1;

   // One request beat.
   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] push_value;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic               accepted;
      logic signed [31:0] top_value;
      logic signed [31:0] min_value;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   // One stack entry: the value and the minimum of it and everything below.
   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] run_min;
   } entry_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_POP_WAIT
   } state_type;

endpackage

@@ design/mts_ram.sv @@
// Entry storage for the min-tracking stack: one write port, one read port,
// registered read data. Depends on mts_pkg for the entry type.
module mts_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  mts_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output mts_pkg::entry_type rd_data
);
   import mts_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/min_tracking_stack.sv @@
// Min-tracking stack of signed 32-bit values with a running minimum per entry.
// Depends on mts_pkg for types and codes and on mts_ram for entry storage.
//
// Usage:
//   A request beat is taken at a rising edge where start is high and busy is
//   low. req_data carries the operation (push, pop, peek) and the push value.
//   Every request gives exactly one response beat: rsp_valid is high for one
//   cycle with rsp_data holding the accepted flag, the top value, the running
//   minimum, and the empty and full flags after the operation. Top and minimum
//   read -1 on an empty stack.
// Response timing:
//   The top entry lives in a register, so push, peek, a dropped operation and
//   a pop that empties the stack answer in the cycle after acceptance and may
//   be issued every cycle. Any other pop must fetch the new top from the entry
//   memory, whose read data is registered: its answer passes the read register
//   and then the response register, and it holds busy for one cycle.
// Reset:
//   reset (synchronous, active high) empties the stack; memory is not cleared
//   since only entries below the count are ever read.
// The receiver cannot stall: each response is shown for one cycle only.
module min_tracking_stack #(
   parameter int DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mts_pkg::req_type req_data,
   output logic             rsp_valid,
   output mts_pkg::rsp_type rsp_data
);
   import mts_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   entry_type       top_ff, top_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            accept;
   logic            respond;
   logic            acc;
   logic signed [31:0] new_min;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   entry_type       rd_data;

   mts_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff == ST_POP_WAIT);
   assign accept = start && !busy;

   // The new running minimum keeps the one below unless the pushed value is lower.
   assign new_min = ((count_ff != '0) && ($signed(top_ff.run_min) < $signed(req_data.push_value)))
                    ? top_ff.run_min : req_data.push_value;

   // Sequencer: applies the operation, drives the memory ports and builds the response.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      rsp_in       = rsp_ff;
      respond      = 1'b0;
      acc          = 1'b1;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = '{value: req_data.push_value, run_min: new_min};
      rd_en        = 1'b0;
      rd_addr      = AW'(count_ff - CW'(2));
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_PUSH: begin
                     respond = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        acc = 1'b0;
                     end else begin
                        wr_en    = 1'b1;
                        top_in   = wr_data;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_POP: begin
                     if (count_ff == '0) begin
                        acc     = 1'b0;
                        respond = 1'b1;
                     end else if (count_ff == CW'(1)) begin
                        count_in = '0;
                        respond  = 1'b1;
                     end else begin
                        count_in = count_ff - CW'(1);
                        rd_en    = 1'b1;
                        state_in = ST_POP_WAIT;
                     end
                  end
                  default: begin
                     respond = 1'b1;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            // The entry below the popped one arrives from memory.
            top_in   = rd_data;
            respond  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = respond;
      if (respond) begin
         rsp_in.accepted  = acc;
         rsp_in.is_empty  = (count_in == '0);
         rsp_in.is_full   = (count_in == CW'(DEPTH));
         rsp_in.top_value = (count_in == '0) ? EMPTY_READ : top_in.value;
         rsp_in.min_value = (count_in == '0) ? EMPTY_READ : top_in.run_min;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Top entry and response payload.
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds capacity");

   // The memory wait only follows an accepted pop that left entries behind.
   a_wait_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> ($past(start) && ($past(req_data.mode) == MODE_POP)
                       && ($past(count_ff) > CW'(1))))
      else $error("memory wait without a deep pop");

   // No response is shown during the memory wait, and one always follows it.
   a_wait_quiet: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("response during memory wait");

   a_wait_answer: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && rsp_data.accepted && !busy))
      else $error("pop response missing after memory wait");

   // The empty flag of each response agrees with the stored count.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (count_ff == '0)))
      else $error("empty flag disagrees with count");

endmodule
